// File: rtl/core/ekhd_pkg.sv
// Shared types, constants and codes for the key hysteresis detector.
`default_nettype none

package ekhd_pkg;

    localparam int KEY_COUNT_DEF = 8;

    localparam int KEY_W   = 3;
    localparam int RAW_W   = 16;
    localparam int LEVEL_W = 12;
    localparam int MASK_W  = 8;
    localparam int KIND_W  = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam int READ_SHIFT = 4;

    localparam logic [LEVEL_W-1:0] FLOOR_RESET   = LEVEL_W'(500);
    localparam logic [LEVEL_W-1:0] ACTUATE_RESET = LEVEL_W'(800);
    localparam logic [LEVEL_W-1:0] RELEASE_RESET = LEVEL_W'(600);

    // One entry of the per-key store: pressed flag on top of the floor.
    localparam int ENTRY_W = LEVEL_W + 1;

    typedef enum logic [KIND_W-1:0] {
        EV_NONE    = 2'd0,
        EV_PRESS   = 2'd1,
        EV_RELEASE = 2'd2
    } event_kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACTUATE = 2'd0,
        CFG_RELEASE = 2'd1,
        CFG_MASK    = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic               in_range;
        logic               masked;
        logic               sample_ok;
        logic               scan_start;
        logic [RAW_W-1:0]   raw;
        logic               entry_pressed;
        logic [LEVEL_W-1:0] entry_floor;
    } upd_req_t;

    typedef struct packed {
        event_kind_t        kind;
        logic [LEVEL_W-1:0] reading;
        logic [LEVEL_W-1:0] floor_out;
        logic [LEVEL_W-1:0] held_next;
        logic               wr_en;
        logic               wr_pressed;
        logic [LEVEL_W-1:0] wr_floor;
    } upd_resp_t;

endpackage

`default_nettype wire

// File: rtl/core/ekhd_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
`default_nettype none

module ekhd_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 8,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/ekhd_update.sv
// Per-sample reading select, floor tracking and hysteresis compare.
`default_nettype none

module ekhd_update (
    input  wire ekhd_pkg::upd_req_t                   req,
    input  wire logic [ekhd_pkg::LEVEL_W-1:0]         actuate_level,
    input  wire logic [ekhd_pkg::LEVEL_W-1:0]         release_level,
    input  wire logic [ekhd_pkg::LEVEL_W-1:0]         held_reg,
    output ekhd_pkg::upd_resp_t                       resp
);
    import ekhd_pkg::*;

    logic [LEVEL_W-1:0] reading_new;
    logic [LEVEL_W-1:0] held_eff;
    logic               active;
    logic [LEVEL_W-1:0] rd;
    logic [LEVEL_W-1:0] floor_min;
    logic [LEVEL_W:0]   act_sum;
    logic [LEVEL_W:0]   rel_sum;
    logic [LEVEL_W:0]   rd_ext;
    event_kind_t        kind;

    always_comb begin
        reading_new = req.raw[RAW_W-1:READ_SHIFT];
        // scan start clears the held reading before anything else
        held_eff    = req.scan_start ? '0 : held_reg;
        active      = req.in_range && !req.masked;

        if (!active) begin
            rd = '0;
        end else if (req.sample_ok) begin
            rd = reading_new;
        end else begin
            rd = held_eff;
        end

        floor_min = (rd < req.entry_floor) ? rd : req.entry_floor;
        rd_ext    = {1'b0, rd};
        act_sum   = {1'b0, actuate_level} + {1'b0, floor_min};
        rel_sum   = {1'b0, release_level} + {1'b0, floor_min};

        kind = EV_NONE;
        if (active) begin
            if (!req.entry_pressed) begin
                if (rd_ext > act_sum) begin
                    kind = EV_PRESS;
                end
            end else if (rd_ext < rel_sum) begin
                kind = EV_RELEASE;
            end
        end

        resp.kind       = kind;
        resp.reading    = rd;
        if (!req.in_range) begin
            resp.floor_out = '0;
        end else if (req.masked) begin
            resp.floor_out = req.entry_floor;
        end else begin
            resp.floor_out = floor_min;
        end
        resp.held_next  = (active && req.sample_ok) ? reading_new : held_eff;
        resp.wr_en      = active;
        resp.wr_pressed = req.entry_pressed ^ (kind != EV_NONE);
        resp.wr_floor   = floor_min;
    end

endmodule

`default_nettype wire

// File: rtl/core/ec_key_hysteresis_detector_unit.sv
// Top level of the key hysteresis detector with per-key noise floor tracking.
//
// Usage:
//   Input channel (s_*): one word per ADC sample, carrying the key index, the
//   raw 16-bit sample, a sample-ok flag and a scan-start flag. Output channel
//   (m_*): exactly one result word per input word, in order, with the key,
//   the event kind (none, pressed, released), the 12-bit reading compared and
//   the key's noise floor after the update.
//   Configuration: cfg_wr_en/cfg_index/cfg_wdata write actuate level (0),
//   release level (1) and key skip mask (2); write only while
//   the block is idle. Other indexes are ignored.
//   Pipeline: the per-key store is read as a word is accepted into stage
//   1; the compare and write-back run there, and the result is registered
//   on m_* when stage 1 advances. Throughput: one word per cycle while the
//   output is not stalled, set by the single read-modify-write of the
//   per-key store; back-to-back hits on one key are forwarded.
//   Reset: all keys released, all floors 500, held reading 0, levels at
//   their defaults; per-key valid bits stand in for clearing the store, so
//   the block is ready right after reset.
//   Stall: when m_ready is low the result waits in the output register and
//   one more word can still enter and wait in the compute stage.
`default_nettype none

module ec_key_hysteresis_detector_unit #(
    parameter int KEY_COUNT = ekhd_pkg::KEY_COUNT_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,

    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [ekhd_pkg::KEY_W-1:0]        s_key_index,
    input  wire logic [ekhd_pkg::RAW_W-1:0]        s_raw_sample,
    input  wire logic                              s_sample_ok,
    input  wire logic                              s_scan_start,

    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic      [ekhd_pkg::KEY_W-1:0]        m_event_key,
    output logic      [ekhd_pkg::KIND_W-1:0]       m_event_kind,
    output logic      [ekhd_pkg::LEVEL_W-1:0]      m_reading_used,
    output logic      [ekhd_pkg::LEVEL_W-1:0]      m_floor_now,

    input  wire logic                              cfg_wr_en,
    input  wire logic [ekhd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [ekhd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import ekhd_pkg::*;

    localparam int ADDR_W = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
    localparam logic [ENTRY_W-1:0] ENTRY_RESET = {1'b0, FLOOR_RESET};

    // Configuration registers
    logic [LEVEL_W-1:0] actuate_reg, actuate_next;
    logic [LEVEL_W-1:0] release_reg, release_next;
    logic [MASK_W-1:0]  mask_reg,    mask_next;

    // Compute stage (stage 1) registers
    logic               s1_valid_reg, s1_valid_next;
    logic [KEY_W-1:0]   s1_key_reg;
    logic [RAW_W-1:0]   s1_raw_reg;
    logic               s1_ok_reg;
    logic               s1_start_reg;
    logic               s1_entry_valid_reg;
    logic               s1_fwd_hit_reg;
    logic [ENTRY_W-1:0] s1_fwd_data_reg;

    // Held reading and per-key valid bits
    logic [LEVEL_W-1:0]   held_reg, held_next;
    logic [KEY_COUNT-1:0] entry_valid_reg, entry_valid_next;

    // Output register
    logic               m_valid_reg, m_valid_next;
    logic [KEY_W-1:0]   m_key_reg;
    event_kind_t        m_kind_reg;
    logic [LEVEL_W-1:0] m_reading_reg;
    logic [LEVEL_W-1:0] m_floor_reg;

    logic               s_accept;
    logic               s1_adv;
    logic [KEY_W+ADDR_W-1:0] in_key_ext;
    logic [KEY_W+ADDR_W-1:0] s1_key_ext;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  wr_addr;
    logic               wr_en;
    logic [ENTRY_W-1:0] wr_data;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [ENTRY_W-1:0] entry_data;
    logic               fwd_hit;
    logic               s1_in_range;
    upd_req_t           upd_req;
    upd_resp_t          upd_resp;

    // ---------------------------------------------------------------
    // Configuration decode
    // ---------------------------------------------------------------
    always_comb begin
        actuate_next = actuate_reg;
        release_next = release_reg;
        mask_next    = mask_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_ACTUATE: actuate_next = cfg_wdata[LEVEL_W-1:0];
                CFG_RELEASE: release_next = cfg_wdata[LEVEL_W-1:0];
                CFG_MASK:    mask_next    = cfg_wdata[MASK_W-1:0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            actuate_reg <= ACTUATE_RESET;
            release_reg <= RELEASE_RESET;
            mask_reg    <= '0;
        end else begin
            actuate_reg <= actuate_next;
            release_reg <= release_next;
            mask_reg    <= mask_next;
        end
    end

    // ---------------------------------------------------------------
    // Handshake: stage 1 advances when the output register is free or
    // being drained; a new word enters when stage 1 is empty or empties this cycle.
    // ---------------------------------------------------------------
    assign s1_adv   = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !s1_valid_reg || s1_adv;
    assign s_accept = s_valid && s_ready;

    // Map the 3-bit key onto the store address width.
    assign in_key_ext = {{ADDR_W{1'b0}}, s_key_index};
    assign s1_key_ext = {{ADDR_W{1'b0}}, s1_key_reg};
    assign rd_addr    = in_key_ext[ADDR_W-1:0];
    assign wr_addr    = s1_key_ext[ADDR_W-1:0];
    assign s1_in_range = (32'(s1_key_reg) < KEY_COUNT);

    // Write-back in the same cycle as a read of the same entry: the RAM
    // returns stale data, so capture the write data instead.
    assign fwd_hit = wr_en && (wr_addr == rd_addr);

    ekhd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (KEY_COUNT)
    ) u_key_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (s_accept),
        .rd_addr (rd_addr),
        .rd_data (ram_rdata)
    );

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_adv) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_key_reg      <= s_key_index;
            s1_raw_reg      <= s_raw_sample;
            s1_ok_reg       <= s_sample_ok;
            s1_start_reg    <= s_scan_start;
            s1_fwd_hit_reg  <= fwd_hit;
            s1_fwd_data_reg <= wr_data;
            // out-of-range keys never use this bit
            s1_entry_valid_reg <= (32'(s_key_index) < KEY_COUNT) ?
                                  entry_valid_reg[rd_addr] : 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: pick the entry, update, write back
    // ---------------------------------------------------------------
    always_comb begin
        if (s1_fwd_hit_reg) begin
            entry_data = s1_fwd_data_reg;
        end else if (s1_entry_valid_reg) begin
            entry_data = ram_rdata;
        end else begin
            entry_data = ENTRY_RESET;
        end
    end

    always_comb begin
        upd_req.in_range      = s1_in_range;
        upd_req.masked        = mask_reg[s1_key_reg];
        upd_req.sample_ok     = s1_ok_reg;
        upd_req.scan_start    = s1_start_reg;
        upd_req.raw           = s1_raw_reg;
        upd_req.entry_pressed = entry_data[ENTRY_W-1];
        upd_req.entry_floor   = entry_data[LEVEL_W-1:0];
    end

    ekhd_update u_update (
        .req           (upd_req),
        .actuate_level (actuate_reg),
        .release_level (release_reg),
        .held_reg      (held_reg),
        .resp          (upd_resp)
    );

    assign wr_en   = s1_adv && upd_resp.wr_en;
    assign wr_data = {upd_resp.wr_pressed, upd_resp.wr_floor};

    always_comb begin
        held_next        = held_reg;
        entry_valid_next = entry_valid_reg;
        if (s1_adv) begin
            held_next = upd_resp.held_next;
        end
        if (wr_en) begin
            entry_valid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg        <= '0;
            entry_valid_reg <= '0;
        end else begin
            held_reg        <= held_next;
            entry_valid_reg <= entry_valid_next;
        end
    end

    // ---------------------------------------------------------------
    // Output register: load on advance, drop on take
    // ---------------------------------------------------------------
    always_comb begin
        m_valid_next = m_valid_reg;
        if (s1_adv) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            m_key_reg     <= s1_key_reg;
            m_kind_reg    <= upd_resp.kind;
            m_reading_reg <= upd_resp.reading;
            m_floor_reg   <= upd_resp.floor_out;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_event_key    = m_key_reg;
    assign m_event_kind   = m_kind_reg;
    assign m_reading_used = m_reading_reg;
    assign m_floor_now    = m_floor_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_valid_after_write: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |=> entry_valid_reg[$past(wr_addr)])
        else $error("valid bit not set after store write");

    a_press_above_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_adv && (upd_resp.kind == EV_PRESS)) |->
        (upd_resp.reading > upd_resp.floor_out))
        else $error("press reported with reading not above floor");

    a_idle_key_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_adv && (!s1_in_range || mask_reg[s1_key_reg])) |->
        ((upd_resp.kind == EV_NONE) && !wr_en))
        else $error("masked or out-of-range key changed state");

    a_floor_never_rises: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (upd_resp.wr_floor <= entry_data[LEVEL_W-1:0]))
        else $error("noise floor increased");

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
// Testbench for the key hysteresis detector: directed and random samples checked against a predictor.
`timescale 1ns / 100ps

module testbench;
    import ekhd_pkg::*;

    // Cycles without any word moving on either channel before the run is declared hung.
    localparam int STALL_LIMIT = 1000;
    localparam int RANDOM_PHASES = 5;
    localparam int WORDS_PER_PHASE = 100;

    // Index outside the register map; the block must ignore writes to it.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = {LEVEL_W{1'b1}};

    // One expected result word.
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        event_kind_t        kind;
        logic [LEVEL_W-1:0] reading;
        logic [LEVEL_W-1:0] floor_val;
    } key_event_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [KEY_W-1:0]      s_key_index = '0;
    logic [RAW_W-1:0]      s_raw_sample = '0;
    logic                  s_sample_ok = 1'b0;
    logic                  s_scan_start = 1'b0;

    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [KEY_W-1:0]      m_event_key;
    logic [KIND_W-1:0]     m_event_kind;
    logic [LEVEL_W-1:0]    m_reading_used;
    logic [LEVEL_W-1:0]    m_floor_now;

    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Predictor state: a private copy of the block's registers and per-key store.
    logic [LEVEL_W-1:0] actuate_lvl = ACTUATE_RESET;
    logic [LEVEL_W-1:0] release_lvl = RELEASE_RESET;
    logic [MASK_W-1:0]  skip_mask = '0;
    logic               key_down [KEY_COUNT_DEF];
    logic [LEVEL_W-1:0] key_floor [KEY_COUNT_DEF];
    logic [LEVEL_W-1:0] held_reading = '0;

    key_event_t expected_events [$];
    int  mismatch_count = 0;
    int  stall_cycles = 0;
    // Set to run both sides without any idle cycles.
    bit  steady_flow = 1'b0;

    ec_key_hysteresis_detector_unit dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_key_index    (s_key_index),
        .s_raw_sample   (s_raw_sample),
        .s_sample_ok    (s_sample_ok),
        .s_scan_start   (s_scan_start),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_event_key    (m_event_key),
        .m_event_kind   (m_event_kind),
        .m_reading_used (m_reading_used),
        .m_floor_now    (m_floor_now),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    initial begin
        for (int k = 0; k < KEY_COUNT_DEF; k++) begin
            key_down[k] = 1'b0;
            key_floor[k] = FLOOR_RESET;
        end
    end

    // Work out the result word for one accepted sample and advance the predictor state.
    function automatic key_event_t predict_key_event(input logic [KEY_W-1:0] key,
                                                     input logic [RAW_W-1:0] raw,
                                                     input logic ok,
                                                     input logic start);
        key_event_t ev;
        logic [LEVEL_W:0] press_at;
        logic [LEVEL_W:0] release_at;
        ev.key = key;
        ev.kind = EV_NONE;
        ev.reading = '0;
        ev.floor_val = '0;
        // Scan start clears the held reading even for a skipped key.
        if (start)
            held_reading = '0;
        if (skip_mask[key]) begin
            // Skipped key: sample not taken, floor reported but left alone.
            ev.floor_val = key_floor[key];
        end else begin
            if (ok)
                held_reading = raw[RAW_W-1:READ_SHIFT];
            ev.reading = held_reading;
            // Lower the floor first, then compare against the updated floor.
            if (held_reading < key_floor[key])
                key_floor[key] = held_reading;
            ev.floor_val = key_floor[key];
            // Thresholds are 13-bit sums so a high level never wraps around.
            press_at = {1'b0, actuate_lvl} + {1'b0, key_floor[key]};
            release_at = {1'b0, release_lvl} + {1'b0, key_floor[key]};
            if (!key_down[key]) begin
                if ({1'b0, ev.reading} > press_at) begin
                    key_down[key] = 1'b1;
                    ev.kind = EV_PRESS;
                end
            end else if ({1'b0, ev.reading} < release_at) begin
                key_down[key] = 1'b0;
                ev.kind = EV_RELEASE;
            end
        end
        return ev;
    endfunction

    // Draw the idle cycles one side inserts before its next word.
    function automatic int draw_gap();
        if (steady_flow)
            return 0;
        if ($urandom_range(0, 3) == 0)
            return 0;
        return int'($urandom_range(0, 12));
    endfunction

    // Build a raw ADC word whose reading is the given level, with random low bits.
    function automatic logic [RAW_W-1:0] raw_for(input logic [LEVEL_W-1:0] level);
        logic [READ_SHIFT-1:0] noise;
        noise = READ_SHIFT'($urandom);
        return {level, noise};
    endfunction

    function automatic logic [LEVEL_W-1:0] clamp_level(input int v);
        if (v < 0)
            return '0;
        if (v > int'(LEVEL_MAX))
            return LEVEL_MAX;
        return v[LEVEL_W-1:0];
    endfunction

    // Pick a reading that lands near this key's press or release point most of the time.
    function automatic logic [LEVEL_W-1:0] pick_reading(input logic [KEY_W-1:0] key);
        int base;
        base = int'(key_floor[key]);
        case ($urandom_range(0, 7))
            0, 1:    return LEVEL_W'($urandom_range(0, LEVEL_MAX));
            2, 3, 4: return clamp_level(base + int'(actuate_lvl)
                                        + int'($urandom_range(0, 6)) - 3);
            5, 6:    return clamp_level(base + int'(release_lvl)
                                        + int'($urandom_range(0, 6)) - 3);
            default: return clamp_level(base - int'($urandom_range(0, 16)));
        endcase
    endfunction

    // Send one sample word; hold it until accepted, then record what must come back.
    task automatic send_sample(input logic [KEY_W-1:0] key, input logic [RAW_W-1:0] raw,
                               input logic ok, input logic start);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_key_index <= key;
        s_raw_sample <= raw;
        s_sample_ok <= ok;
        s_scan_start <= start;
        do @(posedge aclk); while (!s_ready);
        expected_events.push_back(predict_key_event(key, raw, ok, start));
    endtask

    // Drop valid and hold off until every expected result word has come back.
    task automatic settle_idle();
        s_valid <= 1'b0;
        while (expected_events.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    // Write all three registers back to back, plus one write to the unused index.
    // Call only while the block is idle.
    task automatic load_config(input logic [LEVEL_W-1:0] act, input logic [LEVEL_W-1:0] rel,
                               input logic [CFG_DATA_W-1:0] mask_word);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_ACTUATE;
        cfg_wdata <= act;
        @(posedge aclk);
        cfg_index <= CFG_RELEASE;
        cfg_wdata <= rel;
        @(posedge aclk);
        cfg_index <= CFG_MASK;
        cfg_wdata <= mask_word;
        @(posedge aclk);
        cfg_index <= CFG_SPARE;
        cfg_wdata <= CFG_DATA_W'($urandom);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        actuate_lvl = act;
        release_lvl = rel;
        skip_mask = mask_word[MASK_W-1:0];
        @(posedge aclk);
    endtask

    // Reset levels: press, hold, release, failed reads and scan-start clearing.
    task automatic test_reset_defaults();
        send_sample(3'd0, raw_for(12'd2000), 1'b1, 1'b1);
        send_sample(3'd0, raw_for(12'd2000), 1'b1, 1'b0);
        send_sample(3'd0, raw_for(12'd1000), 1'b1, 1'b0);
        // Failed read at scan start reuses the cleared reading of zero.
        send_sample(3'd1, 16'h0000, 1'b0, 1'b1);
        send_sample(3'd2, 16'hFFFF, 1'b1, 1'b0);
        // Failed read mid-scan reuses the previous key's reading.
        send_sample(3'd3, 16'h1234, 1'b0, 1'b0);
        send_sample(3'd3, 16'h000F, 1'b1, 1'b0);
        settle_idle();
    endtask

    // Exact boundaries: equal to the threshold does nothing, one past it acts.
    task automatic test_threshold_edges();
        send_sample(3'd5, raw_for(12'd1300), 1'b1, 1'b1);
        send_sample(3'd5, raw_for(12'd1301), 1'b1, 1'b0);
        send_sample(3'd5, raw_for(12'd1100), 1'b1, 1'b0);
        send_sample(3'd5, raw_for(12'd1099), 1'b1, 1'b0);
        // Drop the floor of key 6, then press relative to the new floor.
        send_sample(3'd6, raw_for(12'd100), 1'b1, 1'b0);
        send_sample(3'd6, raw_for(12'd901), 1'b1, 1'b0);
        settle_idle();
    endtask

    // Skipped keys keep the held reading and their floor; scan start still clears it.
    task automatic test_skip_mask();
        load_config(ACTUATE_RESET, RELEASE_RESET, 12'hF5A);
        send_sample(3'd0, raw_for(12'd900), 1'b1, 1'b1);
        send_sample(3'd1, raw_for(12'd10), 1'b1, 1'b0);
        send_sample(3'd2, 16'h0000, 1'b0, 1'b0);
        send_sample(3'd3, 16'h0000, 1'b1, 1'b1);
        send_sample(3'd5, 16'hFFFF, 1'b0, 1'b0);
        settle_idle();
    endtask

    // Level extremes: zero levels press on any rise and never release; full
    // levels never press and release almost always.
    task automatic test_level_extremes();
        load_config('0, '0, 12'h0FF);
        load_config('0, '0, '0);
        send_sample(3'd7, raw_for(12'd4095), 1'b1, 1'b1);
        send_sample(3'd7, raw_for(12'd0), 1'b1, 1'b0);
        send_sample(3'd4, raw_for(12'd1), 1'b1, 1'b0);
        settle_idle();
        load_config(LEVEL_MAX, LEVEL_MAX, '0);
        send_sample(3'd7, raw_for(12'd4095), 1'b1, 1'b0);
        send_sample(3'd1, raw_for(12'd4095), 1'b1, 1'b0);
        send_sample(3'd4, raw_for(12'd2000), 1'b1, 1'b0);
        settle_idle();
    endtask

    // Random phases: mostly whole scans with shaped readings, some broken scans
    // and pure noise words, under a fresh configuration per phase.
    task automatic test_random_scans();
        int sent;
        int scan_len;
        logic [KEY_W-1:0] first_key;
        logic [KEY_W-1:0] key;
        logic [MASK_W-1:0] mask;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            settle_idle();
            mask = ($urandom_range(0, 2) == 0) ? '0 : MASK_W'($urandom & $urandom);
            load_config(($urandom_range(0, 4) == 0) ? LEVEL_MAX
                                                    : LEVEL_W'($urandom_range(0, 1200)),
                        ($urandom_range(0, 4) == 0) ? '0
                                                    : LEVEL_W'($urandom_range(0, 1000)),
                        {4'($urandom), mask});
            // First phase runs with no idle cycles on either side.
            steady_flow = (phase == 0);
            sent = 0;
            while (sent < WORDS_PER_PHASE) begin
                if ($urandom_range(0, 4) == 0) begin
                    send_sample(KEY_W'($urandom), RAW_W'($urandom),
                                1'($urandom), 1'($urandom));
                    sent++;
                end else begin
                    first_key = KEY_W'($urandom);
                    scan_len = ($urandom_range(0, 3) == 0) ?
                               int'($urandom_range(1, 7)) : 8;
                    for (int i = 0; i < scan_len; i++) begin
                        key = KEY_W'(int'(first_key) + i);
                        send_sample(key, raw_for(pick_reading(key)),
                                    $urandom_range(0, 9) != 0, i == 0);
                        sent++;
                    end
                end
            end
        end
        steady_flow = 1'b0;
        settle_idle();
    endtask

    // Result side: stall a random number of cycles, then take one word.
    initial begin
        int gap;
        @(posedge aclk iff aresetn);
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    task automatic check_field(input string name, input logic [LEVEL_W-1:0] want,
                               input logic [LEVEL_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Compare every accepted result word against the oldest expectation.
    always @(posedge aclk) begin : result_check
        key_event_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_events.size() == 0) begin
                $display("%0t: unexpected result word key %0d kind %0d reading %0d floor %0d",
                         $time, m_event_key, m_event_kind, m_reading_used, m_floor_now);
                mismatch_count++;
            end else begin
                want = expected_events.pop_front();
                check_field("event_key", LEVEL_W'(want.key), LEVEL_W'(m_event_key));
                check_field("event_kind", LEVEL_W'(want.kind), LEVEL_W'(m_event_kind));
                check_field("reading_used", want.reading, m_reading_used);
                check_field("floor_now", want.floor_val, m_floor_now);
            end
        end
    end

    // Watchdog: end the run if no word moves on either channel for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("ec_key_hysteresis_detector_unit verification failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_threshold_edges();
        test_skip_mask();
        test_level_extremes();
        test_random_scans();
        // Let the pipeline drain and catch any stray word.
        repeat (4) @(posedge aclk);
        if (mismatch_count == 0 && expected_events.size() == 0) begin
            $display("ec_key_hysteresis_detector_unit verification clean");
        end else begin
            $display("ec_key_hysteresis_detector_unit verification failed");
        end
        $finish;
    end

endmodule
